### design/hash_table_accumulate_assert.svh
// Assertion macros for the hash table accumulate block.
// No dependencies; included by the checker module.
`ifndef HASH_TABLE_ACCUMULATE_ASSERT_SVH
`define HASH_TABLE_ACCUMULATE_ASSERT_SVH

// check c in the same cycle as a
`define HTA_ASSERT_NOW(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
		else $error("hta check failed");

// check c in the cycle after a
`define HTA_ASSERT_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
		else $error("hta check failed");

`endif

### design/hta_pkg.sv
// Package for the hash table accumulate block: sizes, codes, hash constants.
// No dependencies.
package hta_pkg;
	localparam int CAPACITY  = 4096;
	localparam int KEY_BYTES = 8;
	localparam int SLOT_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int BYTE_W    = $clog2(KEY_BYTES + 1);
	localparam int WORD_W    = 64;
	localparam int LIMIT_W   = 13;

	localparam logic [WORD_W-1:0] FNV_BASIS   = 64'd1469598103934665603;
	localparam logic [WORD_W-1:0] FNV_PRIME_LO = 64'h1b3;
	localparam int FNV_PRIME_SH = 40;
	localparam logic [WORD_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {WORD_W{1'b1}} :
		((64'd1 << (8 * KEY_BYTES)) - 64'd1);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2867;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_NEW  = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SLOT_W-1:0] slot_t;
endpackage

### design/hta_if.sv
// Handshake channels for request and response words.
// Depends on hta_pkg.
interface hta_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	hta_pkg::word_t key;
	hta_pkg::word_t delta;
	logic [11:0] slot_index;
	modport source (output valid, operation, key, delta, slot_index, input ready);
	modport sink (input valid, operation, key, delta, slot_index, output ready);
endinterface

interface hta_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic slot_valid;
	hta_pkg::word_t key_out;
	hta_pkg::word_t count_out;
	logic saturated;
	logic [11:0] slot_used;
	logic [12:0] entries_held;
	modport source (output valid, status, slot_valid, key_out, count_out, saturated,
		slot_used, entries_held, input ready);
	modport sink (input valid, status, slot_valid, key_out, count_out, saturated,
		slot_used, entries_held, output ready);
endinterface

### design/hta_hash.sv
// FNV-1a-like hash, one key byte per cycle, lowest byte first.
// Depends on hta_pkg.
module hta_hash (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  hta_pkg::word_t key_in,
	output logic done,
	output hta_pkg::word_t hash
);
	import hta_pkg::*;

	word_t h_q, k_q, x;
	logic [BYTE_W-1:0] cnt_q;
	logic busy_q, done_q;

	assign x = h_q ^ {{(WORD_W-8){1'b0}}, k_q[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BYTE_W'(KEY_BYTES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= FNV_BASIS;
			k_q <= key_in;
		end else if (busy_q) begin
			h_q <= (x << FNV_PRIME_SH) + x * FNV_PRIME_LO;
			k_q <= k_q >> 8;
		end
	end

	assign done = done_q;
	assign hash = h_q;
endmodule

### design/hash_table_accumulate.sv
// Add: hash the key, then read and compare each slot probed. Read: read and compare
// the indexed slot. Clear: sweep all slot flags. Each then finishes with a response.
// One word in flight at a time; the probe walk over the slot memories sets the rate.
// The response register lets the next word in. After reset all slot flags are swept
// clear with ready low. Depends on hta_pkg, hta_if, hta_hash.
module hash_table_accumulate (
	input  logic clk,
	input  logic arst_n,
	hta_req_if.sink req,
	hta_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic [12:0] cfg_wdata
);
	import hta_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_CLR  = 3'd5;

	word_t key_mem [CAPACITY];
	word_t count_mem [CAPACITY];
	logic  full_mem [CAPACITY];

	logic [2:0] state_q;
	logic [1:0] op_q;
	word_t key_q, delta_q;
	slot_t slot_q, clr_q;
	logic [CNT_W-1:0] probe_q;
	logic [LIMIT_W-1:0] total_q, limit_q;
	logic boot_q;

	word_t rd_key, rd_count;
	logic rd_full;

	logic [1:0] res_status_q;
	logic res_valid_q, res_sat_q;
	word_t res_key_q, res_count_q;
	slot_t res_slot_q;

	logic out_vld_q;
	logic [1:0] out_status_q;
	logic out_valid_q, out_sat_q;
	word_t out_key_q, out_count_q;
	slot_t out_slot_q;
	logic [LIMIT_W-1:0] out_held_q;

	logic hash_start, hash_done;
	word_t hash;
	logic [WORD_W:0] sum;
	word_t sum_sat;
	logic hit, accept, out_load;
	logic new_we, acc_we, flag_we, flag_d;
	slot_t flag_a;

	hta_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start), .key_in(req.key & KEY_MASK),
		.done(hash_done), .hash(hash)
	);

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign hash_start = accept && (req.operation == OP_ADD);
	assign out_load   = (state_q == S_FIN) && (!out_vld_q || rsp.ready);

	assign sum     = {1'b0, rd_count} + {1'b0, delta_q};
	assign sum_sat = sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
	assign hit     = rd_full && (rd_key == key_q);

	always_comb begin
		new_we = 1'b0;
		acc_we = 1'b0;
		if (state_q == S_CMP && op_q == OP_ADD) begin
			acc_we = hit;
			new_we = !rd_full && (total_q < limit_q);
		end
	end

	assign flag_we = new_we || (state_q == S_CLR);
	assign flag_a  = (state_q == S_CLR) ? clr_q : slot_q;
	assign flag_d  = (state_q != S_CLR);

	always_ff @(posedge clk) begin
		if (new_we)
			key_mem[slot_q] <= key_q;
		if (new_we || acc_we)
			count_mem[slot_q] <= new_we ? delta_q : sum_sat;
		if (flag_we)
			full_mem[flag_a] <= flag_d;
		rd_key   <= key_mem[slot_q];
		rd_count <= count_mem[slot_q];
		rd_full  <= full_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			boot_q  <= 1'b1;
			clr_q   <= '0;
			total_q <= '0;
			limit_q <= LIMIT_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (req.operation == OP_ADD)
							state_q <= S_HASH;
						else if (req.operation == OP_READ)
							state_q <= S_READ;
						else if (req.operation == OP_CLEAR) begin
							clr_q   <= '0;
							state_q <= S_CLR;
						end else
							state_q <= S_FIN;
					end
				end
				S_HASH: if (hash_done) state_q <= S_READ;
				S_READ: state_q <= S_CMP;
				S_CMP: begin
					if (op_q == OP_ADD && rd_full && !hit
							&& probe_q != CNT_W'(CAPACITY - 1))
						state_q <= S_READ;
					else
						state_q <= S_FIN;
					if (new_we)
						total_q <= total_q + 1'b1;
				end
				S_FIN: if (out_load) state_q <= S_IDLE;
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == slot_t'(CAPACITY - 1)) begin
						total_q <= '0;
						boot_q  <= 1'b0;
						state_q <= boot_q ? S_IDLE : S_FIN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			key_q   <= req.key & KEY_MASK;
			delta_q <= req.delta;
			slot_q  <= req.slot_index[SLOT_W-1:0];
			res_status_q <= ST_DONE;
			res_valid_q  <= 1'b0;
			res_key_q    <= '0;
			res_count_q  <= '0;
			res_sat_q    <= 1'b0;
			res_slot_q   <= '0;
		end
		if (state_q == S_HASH && hash_done) begin
			slot_q  <= hash[SLOT_W-1:0];
			probe_q <= '0;
		end
		if (state_q == S_CMP) begin
			if (op_q == OP_READ) begin
				res_status_q <= ST_DONE;
				res_valid_q  <= rd_full;
				res_key_q    <= rd_full ? rd_key : '0;
				res_count_q  <= rd_full ? rd_count : '0;
				res_slot_q   <= slot_q;
			end else if (hit) begin
				res_status_q <= ST_ACC;
				res_valid_q  <= 1'b1;
				res_key_q    <= key_q;
				res_count_q  <= sum_sat;
				res_sat_q    <= sum[WORD_W];
				res_slot_q   <= slot_q;
			end else if (new_we) begin
				res_status_q <= ST_NEW;
				res_valid_q  <= 1'b1;
				res_key_q    <= key_q;
				res_count_q  <= delta_q;
				res_slot_q   <= slot_q;
			end else begin
				res_status_q <= ST_FULL;
				res_valid_q  <= 1'b0;
				res_key_q    <= key_q;
				res_count_q  <= '0;
				res_slot_q   <= '0;
				slot_q  <= slot_q + 1'b1;
				probe_q <= probe_q + 1'b1;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_valid_q  <= res_valid_q;
			out_key_q    <= res_key_q;
			out_count_q  <= res_count_q;
			out_sat_q    <= res_sat_q;
			out_slot_q   <= res_slot_q;
			out_held_q   <= total_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.status       = out_status_q;
	assign rsp.slot_valid   = out_valid_q;
	assign rsp.key_out      = out_key_q;
	assign rsp.count_out    = out_count_q;
	assign rsp.saturated    = out_sat_q;
	assign rsp.slot_used    = 12'(out_slot_q);
	assign rsp.entries_held = out_held_q;
endmodule

### design/hta_checker.sv
// Port checker for the hash table accumulate block, bound to the top level.
// Depends on hta_pkg and hash_table_accumulate_assert.svh.
`include "hash_table_accumulate_assert.svh"

module hta_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] rsp_status,
	input logic rsp_slot_valid,
	input hta_pkg::word_t rsp_count_out,
	input logic rsp_saturated,
	input logic [11:0] rsp_slot_used,
	input logic [12:0] rsp_entries_held
);
	import hta_pkg::*;

	`HTA_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count_out))
	`HTA_ASSERT_NOW(a_new, clk, arst_n, rsp_valid && rsp_status == ST_NEW, rsp_slot_valid && rsp_entries_held != 13'd0)
	`HTA_ASSERT_NOW(a_full, clk, arst_n, rsp_valid && rsp_status == ST_FULL, !rsp_slot_valid && rsp_count_out == '0 && rsp_slot_used == '0)
	`HTA_ASSERT_NOW(a_sat, clk, arst_n, rsp_valid && rsp_saturated, rsp_status == ST_ACC && rsp_count_out == {WORD_W{1'b1}})
endmodule

bind hash_table_accumulate hta_checker u_hta_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.status), .rsp_slot_valid(rsp.slot_valid),
	.rsp_count_out(rsp.count_out), .rsp_saturated(rsp.saturated),
	.rsp_slot_used(rsp.slot_used), .rsp_entries_held(rsp.entries_held)
);

### tb/sv/tb_hash_table_accumulate.sv
// Testbench for hash_table_accumulate: drives add, read and clear words through
// the request channel and checks every response against a table model kept here.
// Depends on hta_pkg, hta_req_if, hta_rsp_if and hash_table_accumulate.
module tb_hash_table_accumulate;
	import hta_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic slot_valid;
		word_t key_out;
		word_t count_out;
		logic saturated;
		logic [11:0] slot_used;
		logic [12:0] entries_held;
	} hta_rsp_t;

	class hta_table_model;
		word_t keys [CAPACITY];
		word_t counts [CAPACITY];
		bit occupied [CAPACITY];
		int unsigned held;
		int unsigned limit;
		int unsigned last_slot;
		int unsigned mismatches;
		hta_rsp_t pending [$];

		function new();
			foreach (occupied[i]) occupied[i] = 0;
			held = 0;
			limit = LIMIT_RESET;
			last_slot = 0;
			mismatches = 0;
		endfunction

		function word_t fnv1a(word_t k);
			word_t h;
			h = 64'd1469598103934665603;
			for (int b = 0; b < KEY_BYTES; b++) begin
				h = h ^ ((k >> (8 * b)) & 64'hff);
				h = h * 64'd1099511628211;
			end
			return h;
		endfunction

		function void note_request(logic [1:0] op, word_t k, word_t d, logic [11:0] idx);
			hta_rsp_t r;
			int unsigned i;
			word_t s;
			bit done;
			r = '{ST_DONE, 0, 0, 0, 0, 0, 0};
			if (op == OP_ADD) begin
				i = fnv1a(k) & (CAPACITY - 1);
				done = 0;
				r.status = ST_FULL;
				r.key_out = k;
				for (int n = 0; n < CAPACITY && !done; n++) begin
					if (occupied[i]) begin
						if (keys[i] == k) begin
							s = counts[i] + d;
							if (s < counts[i]) begin
								s = '1;
								r.saturated = 1;
							end
							counts[i] = s;
							r.status = ST_ACC;
							r.slot_valid = 1;
							r.count_out = s;
							r.slot_used = i;
							last_slot = i;
							done = 1;
						end else begin
							i = (i + 1) & (CAPACITY - 1);
						end
					end else begin
						if (held < limit) begin
							occupied[i] = 1;
							keys[i] = k;
							counts[i] = d;
							held++;
							r.status = ST_NEW;
							r.slot_valid = 1;
							r.count_out = d;
							r.slot_used = i;
							last_slot = i;
						end
						done = 1;
					end
				end
			end else if (op == OP_READ) begin
				i = idx & (CAPACITY - 1);
				r.slot_used = i;
				if (occupied[i]) begin
					r.slot_valid = 1;
					r.key_out = keys[i];
					r.count_out = counts[i];
				end
			end else if (op == OP_CLEAR) begin
				foreach (occupied[j]) occupied[j] = 0;
				held = 0;
			end
			r.entries_held = held;
			pending.push_back(r);
		endfunction

		function void check_response(hta_rsp_t got);
			hta_rsp_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: status %0d slot %0d", got.status,
						got.slot_used);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp st%0d v%0d k%h c%h s%0d slot%0d n%0d",
						exp.status, exp.slot_valid, exp.key_out, exp.count_out,
						exp.saturated, exp.slot_used, exp.entries_held);
					$display("          got st%0d v%0d k%h c%h s%0d slot%0d n%0d",
						got.status, got.slot_valid, got.key_out, got.count_out,
						got.saturated, got.slot_used, got.entries_held);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [12:0] cfg_wdata;
	int idle_mode;
	hta_table_model table_model;
	word_t key_pool [64];

	hta_req_if req ();
	hta_rsp_if rsp ();

	hash_table_accumulate dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#300000000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		hta_rsp_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.status, rsp.slot_valid, rsp.key_out, rsp.count_out,
				rsp.saturated, rsp.slot_used, rsp.entries_held};
			table_model.check_response(got);
		end
		if (idle_mode == 2)
			rsp.ready <= ($urandom_range(99) >= 73);
		else if (idle_mode == 3)
			rsp.ready <= ($urandom_range(99) >= 18);
		else
			rsp.ready <= 1'b1;
	end

	task automatic send_word(logic [1:0] op, word_t k, word_t d, logic [11:0] idx);
		int gap;
		req.valid <= 1;
		req.operation <= op;
		req.key <= k;
		req.delta <= d;
		req.slot_index <= idx;
		do @(posedge clk); while (!req.ready);
		table_model.note_request(op, k, d, idx);
		if ((idle_mode == 1 && $urandom_range(99) < 73) ||
				(idle_mode == 3 && $urandom_range(99) < 18)) begin
			gap = $urandom_range(1, 5);
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (table_model.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(logic [12:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		table_model.limit = v;
	endtask

	function automatic word_t pick_delta();
		case ($urandom_range(9))
			0: return '1 - $urandom_range(3);
			1: return {$urandom, $urandom};
			2: return 0;
			default: return $urandom_range(1000);
		endcase
	endfunction

	task automatic random_phase(int items, int pool_size);
		word_t k;
		int sel;
		for (int i = 0; i < pool_size; i++) key_pool[i] = {$urandom, $urandom};
		for (int n = 0; n < items; n++) begin
			sel = $urandom_range(99);
			if (sel < 72) begin
				k = ($urandom_range(4) != 0) ? key_pool[$urandom_range(pool_size - 1)] :
					{$urandom, $urandom};
				send_word(OP_ADD, k, pick_delta(), $urandom);
			end else if (sel < 98) begin
				send_word(OP_READ, {$urandom, $urandom}, {$urandom, $urandom},
					$urandom_range(1) ? table_model.last_slot + $urandom_range(2) :
					$urandom_range(4095));
			end else begin
				send_word(OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
			end
			if (n == items / 2) drain();
		end
	endtask

	initial begin
		table_model = new();
		idle_mode = 0;
		arst_n <= 0;
		cfg_we <= 0;
		cfg_wdata <= 0;
		req.valid <= 0;
		req.operation <= OP_ADD;
		req.key <= 0;
		req.delta <= 0;
		req.slot_index <= 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_word(OP_ADD, 0, 0, 0);
		send_word(OP_ADD, '1, '1, 12'hfff);
		send_word(OP_ADD, '1, 1, 0);
		send_word(OP_READ, 0, 0, table_model.last_slot);
		send_word(OP_ADD, 64'h0123456789abcdef, 64'h5555aaaa5555aaaa, 0);
		send_word(OP_ADD, 64'h0123456789abcdef, 64'haaaa5555aaaa5555, 0);
		send_word(OP_READ, 0, 0, table_model.last_slot);
		send_word(OP_READ, '1, '1, 0);
		send_word(OP_READ, 0, 0, 12'hfff);
		for (int i = 0; i < 6; i++) send_word(OP_ADD, i, 1, 0);
		send_word(OP_CLEAR, 0, 0, 0);
		send_word(OP_READ, 0, 0, table_model.last_slot);
		write_limit(1);
		send_word(OP_ADD, 64'h77, 3, 0);
		send_word(OP_ADD, 64'h78, 3, 0);
		send_word(OP_ADD, 64'h77, '1, 0);
		send_word(OP_CLEAR, 0, 0, 0);

		write_limit(4096);
		random_phase(400, 64);
		idle_mode = 1;
		write_limit(37);
		random_phase(400, 64);
		idle_mode = 2;
		write_limit(1);
		random_phase(300, 8);
		idle_mode = 3;
		write_limit(300);
		random_phase(400, 64);
		idle_mode = 0;
		write_limit(LIMIT_RESET);
		random_phase(500, 64);

		drain();
		repeat (50) @(posedge clk);
		if (table_model.mismatches == 0 && table_model.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
